>>> src/slot_free_list_allocator_unit_assert.svh
// Assertion macros used by the allocator RTL in sfla_back.
`ifndef SLOT_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH
`define SLOT_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SFLA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfla: same-cycle check failed");

// next-cycle implication
`define SFLA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfla: next-cycle check failed");

`endif

>>> src/sfla_pkg.sv
package sfla_pkg;

	localparam int POOL_SLOTS  = 256;
	localparam int MAX_RUN     = 64;
	localparam int SLOT_W      = $clog2(POOL_SLOTS);
	localparam int FREE_W      = $clog2(POOL_SLOTS + 1);
	localparam int CNT_W       = $clog2(MAX_RUN + 1);
	localparam int RUN_W       = 7;
	localparam int REQ_W       = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [FREE_W-1:0] LOW_MARK_RST = FREE_W'(64);

	// request codes as seen on the port
	localparam logic [REQ_W-1:0] REQ_ALLOC_ONE  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_ALLOC_RUN  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_FREE_ONE   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_FREE_CHAIN = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SET_LINK   = 3'd4;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SHORT    = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// internal command classes after decode
	typedef enum logic [1:0] {
		CMD_ALLOC,
		CMD_FREE,
		CMD_LINK,
		CMD_NOP
	} cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_WALK
	} back_state_t;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [SLOT_W-1:0] slot;
		logic [SLOT_W-1:0] last_slot;
		logic [RUN_W-1:0]  run_count;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] granted_slot;
		status_t           status;
		logic              last_of_run;
		logic [FREE_W-1:0] free_left;
		logic              pool_low;
	} rsp_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [SLOT_W-1:0] first;
		logic [SLOT_W-1:0] last;
		logic [CNT_W-1:0]  count;
	} cmd_entry_t;

endpackage

>>> src/sfla_ram.sv
module sfla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> src/sfla_front.sv
module sfla_front
	import sfla_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  req_t       req,
	output logic       busy,
	output logic       q_valid,
	output cmd_entry_t q_entry,
	input  logic       q_pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_entry_t          ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	cmd_entry_t          dec;
	logic [CNT_W-1:0]    cnt_clamped;
	logic                push;
	logic                pop;

	// count 0 acts as 1, anything above the run limit is cut to it
	always_comb begin
		if (req.run_count == '0) begin
			cnt_clamped = CNT_W'(1);
		end else if (CNT_W'(req.run_count) > CNT_W'(MAX_RUN)) begin
			cnt_clamped = CNT_W'(MAX_RUN);
		end else begin
			cnt_clamped = CNT_W'(req.run_count);
		end
	end

	// single free is a one-slot chain whose first and last coincide
	always_comb begin
		dec.first = req.slot;
		dec.last  = req.last_slot;
		dec.count = cnt_clamped;
		unique case (req.req_type)
			REQ_ALLOC_ONE: begin
				dec.cmd   = CMD_ALLOC;
				dec.count = CNT_W'(1);
			end
			REQ_ALLOC_RUN: begin
				dec.cmd = CMD_ALLOC;
			end
			REQ_FREE_ONE: begin
				dec.cmd   = CMD_FREE;
				dec.last  = req.slot;
				dec.count = CNT_W'(1);
			end
			REQ_FREE_CHAIN: begin
				dec.cmd = CMD_FREE;
			end
			REQ_SET_LINK: begin
				dec.cmd = CMD_LINK;
			end
			default: begin
				dec.cmd = CMD_NOP;
			end
		endcase
	end

	assign busy    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign push    = start && !busy;
	assign q_valid = (cnt_q != '0);
	assign pop     = q_pop && q_valid;
	assign q_entry = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> src/sfla_back.sv
`include "slot_free_list_allocator_unit_assert.svh"

module sfla_back
	import sfla_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  cmd_entry_t        q_entry,
	output logic              q_pop,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [FREE_W-1:0] cfg_data,
	output logic              rsp_valid,
	output rsp_t              rsp
);

	back_state_t          state_q, state_d;
	logic [SLOT_W-1:0]    head_q, head_d;
	logic [FREE_W-1:0]    free_q, free_d;
	logic [FREE_W-1:0]    low_mark_q;
	logic [CNT_W-1:0]     remain_q, remain_d;
	logic [SLOT_W-1:0]    cur_q, cur_d;
	logic [POOL_SLOTS-1:0] vld_q;
	logic                 rd_vld_q;

	logic                 wr_en, rd_en;
	logic [SLOT_W-1:0]    wr_addr, wr_data, rd_addr, rd_data;
	logic [SLOT_W-1:0]    nxt;
	logic [FREE_W:0]      free_sum;

	logic                 emit;
	logic [SLOT_W-1:0]    emit_slot;
	status_t              emit_status;
	logic                 emit_last;

	sfla_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (POOL_SLOTS)
	) u_link_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign cfg_ready = 1'b1;

	// a link never written still holds its reset successor
	assign nxt = rd_vld_q ? rd_data
		: ((cur_q == SLOT_W'(POOL_SLOTS - 1)) ? '0 : cur_q + 1'b1);

	assign free_sum = {1'b0, free_q} + (FREE_W + 1)'(q_entry.count);

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		free_d      = free_q;
		remain_d    = remain_q;
		cur_d       = cur_q;
		q_pop       = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = head_q;
		wr_en       = 1'b0;
		wr_addr     = q_entry.last;
		wr_data     = head_q;
		emit        = 1'b0;
		emit_slot   = '0;
		emit_status = ST_OK;
		emit_last   = 1'b1;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					unique case (q_entry.cmd)
						CMD_ALLOC: begin
							if (free_q < FREE_W'(q_entry.count)) begin
								emit        = 1'b1;
								emit_status = ST_SHORT;
							end else begin
								rd_en    = 1'b1;
								rd_addr  = head_q;
								cur_d    = head_q;
								remain_d = q_entry.count;
								free_d   = free_q - FREE_W'(q_entry.count);
								state_d  = BK_WALK;
							end
						end
						CMD_FREE: begin
							emit = 1'b1;
							if (free_sum > (FREE_W + 1)'(POOL_SLOTS)) begin
								emit_status = ST_OVERFLOW;
							end else begin
								// splice chain in front of the list
								wr_en   = 1'b1;
								wr_addr = q_entry.last;
								wr_data = head_q;
								head_d  = q_entry.first;
								free_d  = free_sum[FREE_W-1:0];
							end
						end
						CMD_LINK: begin
							emit    = 1'b1;
							wr_en   = 1'b1;
							wr_addr = q_entry.first;
							wr_data = q_entry.last;
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			BK_WALK: begin
				emit      = 1'b1;
				emit_slot = cur_q;
				emit_last = (remain_q == CNT_W'(1));
				head_d    = nxt;
				if (remain_q == CNT_W'(1)) begin
					state_d = BK_IDLE;
				end else begin
					rd_en    = 1'b1;
					rd_addr  = nxt;
					cur_d    = nxt;
					remain_d = remain_q - 1'b1;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			head_q     <= '0;
			free_q     <= FREE_W'(POOL_SLOTS);
			low_mark_q <= LOW_MARK_RST;
			remain_q   <= '0;
			vld_q      <= '0;
			rsp_valid  <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			free_q    <= free_d;
			remain_q  <= remain_d;
			rsp_valid <= emit;
			if (cfg_valid && cfg_ready) begin
				low_mark_q <= cfg_data;
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		if (rd_en) begin
			rd_vld_q <= vld_q[rd_addr];
		end
		if (emit) begin
			rsp.granted_slot <= emit_slot;
			rsp.status       <= emit_status;
			rsp.last_of_run  <= emit_last;
			rsp.free_left    <= free_d;
			rsp.pool_low     <= (free_d < low_mark_q);
		end
	end

	`SFLA_ASSERT_NOW(a_free_in_pool, 1'b1, free_q <= FREE_W'(POOL_SLOTS))
	`SFLA_ASSERT_NOW(a_walk_remain, state_q == BK_WALK, remain_q != '0)
	`SFLA_ASSERT_NXT(a_walk_ends, (state_q == BK_WALK) && (remain_q == CNT_W'(1)), state_q == BK_IDLE)
	`SFLA_ASSERT_NOW(a_fail_is_last, rsp_valid && (rsp.status != ST_OK), rsp.last_of_run)
	`SFLA_ASSERT_NOW(a_no_pop_in_walk, state_q == BK_WALK, !q_pop)

endmodule

>>> src/slot_free_list_allocator_unit.sv
// Channel   Handshake              Payload
// request   start / busy           req (req_t)
// result    rsp_valid (strobe)     rsp (rsp_t)
// config    cfg_valid / cfg_ready  cfg_data (low_mark)
//
// Requests enter a two-beat command queue; busy rises only while it is full.
// Frees, link writes, refusals and unknown codes are handled in the executor's idle
// state and answered through the registered result; a granted allocation of n slots
// holds the executor in its walk state, one link-memory read per slot.
// Reset leaves all 256 slots free in order, head at slot 0, low_mark 64; per-slot
// valid bits stand in for reset links, so no clearing pass. Results cannot be stalled.
module slot_free_list_allocator_unit
	import sfla_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  req_t              req,
	output logic              rsp_valid,
	output rsp_t              rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [FREE_W-1:0] cfg_data
);

	logic       q_valid;
	logic       q_pop;
	cmd_entry_t q_entry;

	sfla_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.busy    (busy),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.q_pop   (q_pop)
	);

	sfla_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

>>> tb/slot_free_list_allocator_unit_test.sv
`timescale 1ns / 1ps

module slot_free_list_allocator_unit_test;
	import sfla_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	req_t              req;
	logic              rsp_valid;
	rsp_t              rsp;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [FREE_W-1:0] cfg_data;

	slot_free_list_allocator_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// shadow of the free list
	logic [SLOT_W-1:0] next_free [POOL_SLOTS];
	logic [SLOT_W-1:0] free_head;
	int                free_count;
	int                low_mark_q;

	rsp_t              owed_rsp [$];
	logic [SLOT_W-1:0] owned_slots [$];
	int                err_count;
	int                cycle_count;
	bit                steady;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic req_t make_req(input logic [REQ_W-1:0] kind,
			input logic [SLOT_W-1:0] first, input logic [SLOT_W-1:0] last,
			input logic [RUN_W-1:0] count);
		req_t r;
		r.req_type  = kind;
		r.slot      = first;
		r.last_slot = last;
		r.run_count = count;
		return r;
	endfunction

	function automatic void owe(input logic [SLOT_W-1:0] granted, input status_t st,
			input logic last);
		rsp_t e;
		e.granted_slot = granted;
		e.status       = st;
		e.last_of_run  = last;
		e.free_left    = FREE_W'(free_count);
		e.pool_low     = (free_count < low_mark_q);
		owed_rsp.push_back(e);
	endfunction

	// updates the shadow list and queues the results one request causes
	function automatic void track_request(input req_t r);
		logic [SLOT_W-1:0] walk;
		logic [SLOT_W-1:0] run [$];
		int                n;
		n = (r.run_count == 0) ? 1 :
			(int'(r.run_count) > MAX_RUN) ? MAX_RUN : int'(r.run_count);
		case (r.req_type)
			REQ_ALLOC_ONE: begin
				if (free_count == 0) begin
					owe('0, ST_SHORT, 1'b1);
				end else begin
					walk = free_head;
					free_head = next_free[walk];
					free_count--;
					owned_slots.push_back(walk);
					owe(walk, ST_OK, 1'b1);
				end
			end
			REQ_ALLOC_RUN: begin
				if (free_count < n) begin
					owe('0, ST_SHORT, 1'b1);
				end else begin
					walk = free_head;
					repeat (n) begin
						run.push_back(walk);
						walk = next_free[walk];
					end
					free_head = walk;
					free_count -= n;
					foreach (run[i]) begin
						owned_slots.push_back(run[i]);
						owe(run[i], ST_OK, i == n - 1);
					end
				end
			end
			REQ_FREE_ONE: begin
				if (free_count >= POOL_SLOTS) begin
					owe('0, ST_OVERFLOW, 1'b1);
				end else begin
					next_free[r.slot] = free_head;
					free_head = r.slot;
					free_count++;
					owe('0, ST_OK, 1'b1);
				end
			end
			REQ_FREE_CHAIN: begin
				if (free_count + n > POOL_SLOTS) begin
					owe('0, ST_OVERFLOW, 1'b1);
				end else begin
					next_free[r.last_slot] = free_head;
					free_head = r.slot;
					free_count += n;
					owe('0, ST_OK, 1'b1);
				end
			end
			REQ_SET_LINK: begin
				next_free[r.slot] = r.last_slot;
				owe('0, ST_OK, 1'b1);
			end
			default: begin
				owe('0, ST_OK, 1'b1);
			end
		endcase
	endfunction

	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid) begin
			if (owed_rsp.size() == 0) begin
				$error("unexpected result: granted_slot %0d status %0d",
					rsp.granted_slot, rsp.status);
				err_count++;
			end else begin
				e = owed_rsp.pop_front();
				if (rsp.granted_slot !== e.granted_slot) begin
					$error("granted_slot: expected %0d, got %0d", e.granted_slot,
						rsp.granted_slot);
					err_count++;
				end
				if (rsp.status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, rsp.status);
					err_count++;
				end
				if (rsp.last_of_run !== e.last_of_run) begin
					$error("last_of_run: expected %0d, got %0d", e.last_of_run,
						rsp.last_of_run);
					err_count++;
				end
				if (rsp.free_left !== e.free_left) begin
					$error("free_left: expected %0d, got %0d", e.free_left, rsp.free_left);
					err_count++;
				end
				if (rsp.pool_low !== e.pool_low) begin
					$error("pool_low: expected %0d, got %0d", e.pool_low, rsp.pool_low);
					err_count++;
				end
			end
		end
	end

	// start stays high across back-to-back beats; only lowered for a gap
	task automatic issue_request(input req_t r);
		if (!steady) begin
			while ($urandom_range(99) < 10) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		track_request(r);
	endtask

	task automatic settle();
		start <= 1'b0;
		while (owed_rsp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_low_mark(input int v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= FREE_W'(v);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		low_mark_q = v;
	endtask

	// pool is full out of reset, so both kinds of free are refused
	task automatic test_refused_frees();
		issue_request(make_req(REQ_FREE_ONE, 255, 0, 1));
		issue_request(make_req(REQ_FREE_CHAIN, 0, 255, 0));
	endtask

	// zero count acts as one, 127 clamps to the max run; ends with an empty pool
	task automatic test_alloc_to_empty();
		issue_request(make_req(REQ_ALLOC_ONE, 0, 0, 0));
		issue_request(make_req(REQ_ALLOC_RUN, 255, 255, 0));
		issue_request(make_req(REQ_ALLOC_RUN, 0, 0, 127));
		issue_request(make_req(REQ_ALLOC_RUN, 0, 0, 64));
		issue_request(make_req(REQ_ALLOC_RUN, 0, 0, 64));
		issue_request(make_req(REQ_ALLOC_RUN, 0, 0, 62));
		issue_request(make_req(REQ_ALLOC_ONE, 0, 0, 1));
		issue_request(make_req(REQ_ALLOC_RUN, 0, 0, 1));
	endtask

	task automatic test_low_mark_extremes();
		write_low_mark(256);
		issue_request(make_req(REQ_FREE_ONE, owned_slots.pop_front(), 0, 1));
		write_low_mark(0);
		issue_request(make_req(REQ_FREE_ONE, owned_slots.pop_front(), 0, 1));
		write_low_mark(3);
		issue_request(make_req(REQ_ALLOC_ONE, 0, 0, 1));
		issue_request(make_req(REQ_FREE_ONE, owned_slots.pop_front(), 0, 1));
		write_low_mark(64);
	endtask

	task automatic test_free_and_link();
		logic [SLOT_W-1:0] a;
		logic [SLOT_W-1:0] b;
		a = owned_slots.pop_front();
		b = owned_slots.pop_front();
		issue_request(make_req(REQ_SET_LINK, a, b, 0));
		issue_request(make_req(REQ_FREE_CHAIN, a, b, 2));
		issue_request(make_req(3'd5, 255, 255, 127));
		issue_request(make_req(3'd6, 0, 0, 0));
		issue_request(make_req(3'd7, 255, 255, 127));
		// chain contents are trusted: only the clamped count matters
		issue_request(make_req(REQ_FREE_CHAIN, 0, 255, 127));
		issue_request(make_req(REQ_SET_LINK, 255, 255, 127));
		issue_request(make_req(REQ_ALLOC_RUN, 0, 0, 5));
	endtask

	task automatic test_random_traffic(input int n_items);
		logic [SLOT_W-1:0] chain [$];
		int                sent;
		int                pick;
		int                k;
		int                idx;
		req_t              r;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if ($urandom_range(99) == 0) begin
				settle();
			end
			if (pick < 12) begin
				r = make_req(REQ_W'($urandom_range(7)), SLOT_W'($urandom),
					SLOT_W'($urandom), RUN_W'($urandom));
				issue_request(r);
				sent++;
			end else if (pick < 40 && free_count > 0) begin
				issue_request(make_req(REQ_ALLOC_ONE, SLOT_W'($urandom), SLOT_W'($urandom),
					RUN_W'($urandom)));
				sent++;
			end else if (pick < 55 && free_count > 0) begin
				k = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(1, 8);
				issue_request(make_req(REQ_ALLOC_RUN, SLOT_W'($urandom), SLOT_W'($urandom),
					RUN_W'(k)));
				sent++;
			end else if (pick < 80 && owned_slots.size() > 0) begin
				idx = $urandom_range(owned_slots.size() - 1);
				issue_request(make_req(REQ_FREE_ONE, owned_slots[idx], SLOT_W'($urandom),
					RUN_W'($urandom)));
				owned_slots.delete(idx);
				sent++;
			end else if (owned_slots.size() >= 2) begin
				// link a few owned slots into a chain, then hand it back whole
				k = $urandom_range(2, (owned_slots.size() < 8) ? owned_slots.size() : 8);
				chain.delete();
				repeat (k) begin
					idx = $urandom_range(owned_slots.size() - 1);
					chain.push_back(owned_slots[idx]);
					owned_slots.delete(idx);
				end
				for (int i = 0; i < k - 1; i++) begin
					issue_request(make_req(REQ_SET_LINK, chain[i], chain[i + 1],
						RUN_W'($urandom)));
				end
				issue_request(make_req(REQ_FREE_CHAIN, chain[0], chain[k - 1], RUN_W'(k)));
				sent += k;
			end else begin
				issue_request(make_req(REQ_ALLOC_ONE, SLOT_W'($urandom), SLOT_W'($urandom),
					RUN_W'($urandom)));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		err_count = 0;
		cycle_count = 0;
		steady = 1'b0;
		for (int i = 0; i < POOL_SLOTS; i++) begin
			next_free[i] = SLOT_W'(i + 1);
		end
		free_head = '0;
		free_count = POOL_SLOTS;
		low_mark_q = int'(LOW_MARK_RST);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_refused_frees();
		test_alloc_to_empty();
		test_low_mark_extremes();
		test_free_and_link();
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					write_low_mark(256);
				end
				1: begin
					write_low_mark(0);
				end
				default: begin
					write_low_mark($urandom_range(256));
				end
			endcase
			steady = (phase == 2);
			test_random_traffic(42);
		end

		settle();
		repeat (16) @(posedge clk);
		if (err_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
